FILE: rtl/core/afu_pkg.sv
// Shared types, constants and lookup functions of the activation function unit.
// Used by afu_div, activation_function_unit_top and afu_checker; no dependencies.
package afu_pkg;

    localparam int DATA_W    = 16;
    localparam int FRAC_W    = 8;
    localparam int CFG_IDX_W = 8;
    localparam int EXP_W     = 17;
    localparam int QUO_W     = 17;
    localparam int NUM_W     = 33;
    localparam int DEN_W     = 18;

    typedef enum logic [2:0] {
        MODE_SIGMOID  = 3'd0,
        MODE_RELU     = 3'd1,
        MODE_TANH     = 3'd2,
        MODE_PASS     = 3'd3,
        MODE_ELU      = 3'd4,
        MODE_IDENTITY = 3'd5,
        MODE_SWISH    = 3'd6
    } act_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACT_MODE = 8'd0,
        REG_ELU_COEF = 8'd1,
        REG_ALPHA    = 8'd2,
        REG_BETA     = 8'd3
    } reg_index_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic signed [DATA_W-1:0] prior;
        logic                     last;
        logic [EXP_W-1:0]         expv;
    } side_t;

    function automatic logic [16:0] exp_int_lut(input logic [3:0] n);
        logic [16:0] r;
        case (n)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd24109;
            4'd2:    r = 17'd8869;
            4'd3:    r = 17'd3263;
            4'd4:    r = 17'd1200;
            4'd5:    r = 17'd442;
            4'd6:    r = 17'd162;
            4'd7:    r = 17'd60;
            4'd8:    r = 17'd22;
            4'd9:    r = 17'd8;
            4'd10:   r = 17'd3;
            4'd11:   r = 17'd1;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    function automatic logic [16:0] exp_frac_lut(input logic [3:0] i);
        logic [16:0] r;
        case (i)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd61565;
            4'd2:    r = 17'd57835;
            4'd3:    r = 17'd54331;
            4'd4:    r = 17'd51040;
            4'd5:    r = 17'd47947;
            4'd6:    r = 17'd45042;
            4'd7:    r = 17'd42313;
            4'd8:    r = 17'd39750;
            4'd9:    r = 17'd37341;
            4'd10:   r = 17'd35079;
            4'd11:   r = 17'd32954;
            4'd12:   r = 17'd30957;
            4'd13:   r = 17'd29081;
            4'd14:   r = 17'd27319;
            default: r = 17'd25664;
        endcase
        return r;
    endfunction

    function automatic logic signed [17:0] round_q16(input logic signed [33:0] x);
        logic [33:0] mag;
        logic [17:0] m;
        mag = x[33] ? 34'(-x) : 34'(x);
        m   = 18'((mag + 34'd32768) >> 16);
        return x[33] ? -$signed(m) : $signed(m);
    endfunction

endpackage

FILE: rtl/core/activation_function_unit_top.sv
// Activation function unit: a fully pipelined datapath that applies the configured
// activation to one Q8.8 sample per cycle. It accepts a new item in every cycle that
// the result register is empty or being drained; every sample passes through the
// 17-stage quotient pipeline used by sigmoid, tanh and swish, whatever the mode.
// Configuration writes must be made while the pipeline is empty.
// Depends on afu_pkg and afu_div.
module activation_function_unit_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [afu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [afu_pkg::DATA_W-1:0]          cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [afu_pkg::DATA_W-1:0]   s_sample_in,
    input  logic signed [afu_pkg::DATA_W-1:0]   s_prior_out,
    input  logic                                s_last_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [afu_pkg::DATA_W-1:0]   m_result_out,
    output logic                                m_saturated,
    output logic                                m_last_out
);
    localparam int DW = afu_pkg::DATA_W;

    afu_pkg::act_mode_t       mode_reg;
    logic signed [DW-1:0]     coef_reg, alpha_reg, beta_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= afu_pkg::MODE_IDENTITY;
            coef_reg  <= 16'sd256;
            alpha_reg <= 16'sd256;
            beta_reg  <= 16'sd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                afu_pkg::REG_ACT_MODE: mode_reg  <= afu_pkg::act_mode_t'(cfg_data[2:0]);
                afu_pkg::REG_ELU_COEF: coef_reg  <= cfg_data;
                afu_pkg::REG_ALPHA:    alpha_reg <= cfg_data;
                afu_pkg::REG_BETA:     beta_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, va_reg, vb_reg, vc_reg, vd_reg, m_valid_reg;
    afu_pkg::side_t s1_reg, s2_reg, s3_reg, s4_reg, sa_reg, sb_reg, sc_reg, sd_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // Stage 1: input register.
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg.sample <= s_sample_in;
            s1_reg.prior  <= s_prior_out;
            s1_reg.last   <= s_last_in;
            s1_reg.expv   <= '0;
        end
    end

    // Stage 2: magnitude and exponential table lookups.
    logic signed [DW:0] v_ext;
    logic [DW:0]        mag, t_arg;
    logic [8:0]         n_idx;
    logic [3:0]         r4;
    logic [7:0]         sq;
    logic [16:0]        int2_reg, frac2_reg, p2_reg, p3_reg;
    logic               zero2_reg, zero3_reg;

    assign v_ext = 17'(s1_reg.sample);
    assign mag   = v_ext[DW] ? 17'(-v_ext) : 17'(v_ext);
    assign t_arg = (mode_reg == afu_pkg::MODE_TANH) ? {mag[DW-1:0], 1'b0} : mag;
    assign n_idx = t_arg[16:8];
    assign r4    = t_arg[3:0];
    assign sq    = {4'b0, r4} * {4'b0, r4};

    always_ff @(posedge aclk) begin
        if (en) begin
            int2_reg  <= afu_pkg::exp_int_lut(n_idx[3:0]);
            frac2_reg <= afu_pkg::exp_frac_lut(t_arg[7:4]);
            p2_reg    <= 17'(17'd65536 - 17'({r4, 8'h00}) + 17'(sq[7:1]));
            zero2_reg <= (n_idx >= 9'd12);
            s2_reg    <= s1_reg;
        end
    end

    // Stage 3: integer-part times fraction-part factor.
    logic [33:0] m3;
    logic [16:0] e3_reg;
    assign m3 = {17'b0, int2_reg} * {17'b0, frac2_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            e3_reg    <= m3[32:16];
            p3_reg    <= p2_reg;
            zero3_reg <= zero2_reg;
            s3_reg    <= s2_reg;
        end
    end

    // Stage 4: residual correction factor.
    logic [33:0] m4;
    assign m4 = {17'b0, e3_reg} * {17'b0, p3_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_reg.sample <= s3_reg.sample;
            s4_reg.prior  <= s3_reg.prior;
            s4_reg.last   <= s3_reg.last;
            s4_reg.expv   <= zero3_reg ? 17'd0 : m4[32:16];
        end
    end

    // Divider operands.
    logic [afu_pkg::NUM_W-1:0] num;
    logic [afu_pkg::DEN_W-1:0] den;
    logic                      dv_valid;
    logic [afu_pkg::QUO_W-1:0] quo;
    afu_pkg::side_t            dv_side;

    assign den = 18'(18'd65536 + 18'(s4_reg.expv));

    always_comb begin
        if (mode_reg == afu_pkg::MODE_TANH) begin
            num = {17'(17'd65536 - s4_reg.expv), 16'h0000};
        end else if (s4_reg.sample[DW-1]) begin
            num = {s4_reg.expv, 16'h0000};
        end else begin
            num = 33'h1_0000_0000;
        end
    end

    afu_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (v4_reg),
        .num      (num),
        .den      (den),
        .in_side  (s4_reg),
        .out_valid(dv_valid),
        .quo      (quo),
        .out_side (dv_side)
    );

    // Stage A: swish and ELU products.
    logic signed [17:0] em1;
    logic signed [33:0] swish_reg, elu_reg;
    logic [afu_pkg::QUO_W-1:0] qa_reg;

    assign em1 = $signed({1'b0, dv_side.expv}) - 18'sd65536;

    always_ff @(posedge aclk) begin
        if (en) begin
            swish_reg <= 34'(dv_side.sample) * $signed({17'b0, quo});
            elu_reg   <= 34'(coef_reg) * 34'(em1);
            qa_reg    <= quo;
            sa_reg    <= dv_side;
        end
    end

    // Stage B: rounding and activation select.
    logic [8:0]         qr;
    logic signed [17:0] act, act_reg;
    assign qr = 9'((18'(qa_reg) + 18'd128) >> 8);

    always_comb begin
        case (mode_reg)
            afu_pkg::MODE_SIGMOID: act = $signed({9'b0, qr});
            afu_pkg::MODE_TANH:
                act = sa_reg.sample[DW-1] ? -$signed({9'b0, qr}) : $signed({9'b0, qr});
            afu_pkg::MODE_RELU:
                act = (sa_reg.sample > 0) ? 18'(sa_reg.sample) : 18'sd0;
            afu_pkg::MODE_ELU:
                act = sa_reg.sample[DW-1] ? afu_pkg::round_q16(elu_reg) : 18'(sa_reg.sample);
            afu_pkg::MODE_SWISH:   act = afu_pkg::round_q16(swish_reg);
            default:               act = 18'(sa_reg.sample);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            act_reg <= act;
            sb_reg  <= sa_reg;
        end
    end

    // Stage C: gain products.
    logic signed [33:0] pa_reg, pb_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            pa_reg <= 34'(alpha_reg) * 34'(act_reg);
            pb_reg <= 34'(beta_reg) * 34'(sb_reg.prior);
            sc_reg <= sb_reg;
        end
    end

    // Stage D: blend sum.
    logic signed [34:0] acc_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg <= 35'(pa_reg) + 35'(pb_reg);
            sd_reg  <= sc_reg;
        end
    end

    // Output stage: round, saturate.
    logic [34:0]        acc_mag;
    logic [27:0]        acc_rnd;
    logic signed [28:0] qv;
    logic signed [DW-1:0] res_reg;
    logic               sat_reg, last_reg;

    assign acc_mag = acc_reg[34] ? 35'(-acc_reg) : 35'(acc_reg);
    assign acc_rnd = 28'((acc_mag + 35'd128) >> 8);
    assign qv      = acc_reg[34] ? -$signed({1'b0, acc_rnd}) : $signed({1'b0, acc_rnd});

    always_ff @(posedge aclk) begin
        if (en) begin
            last_reg <= sd_reg.last;
            if (qv > 29'sd32767) begin
                res_reg <= 16'sh7fff;
                sat_reg <= 1'b1;
            end else if (qv < -29'sd32768) begin
                res_reg <= 16'sh8000;
                sat_reg <= 1'b1;
            end else begin
                res_reg <= DW'(qv);
                sat_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            va_reg      <= 1'b0;
            vb_reg      <= 1'b0;
            vc_reg      <= 1'b0;
            vd_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            va_reg      <= dv_valid;
            vb_reg      <= va_reg;
            vc_reg      <= vb_reg;
            vd_reg      <= vc_reg;
            m_valid_reg <= vd_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_result_out = res_reg;
    assign m_saturated  = sat_reg;
    assign m_last_out   = last_reg;

endmodule

FILE: rtl/core/afu_div.sv
// Pipelined restoring divider: an operand register, then one quotient bit per register stage.
// Depends on afu_pkg for widths and the side-band payload type.
module afu_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [afu_pkg::NUM_W-1:0]   num,
    input  logic [afu_pkg::DEN_W-1:0]   den,
    input  afu_pkg::side_t              in_side,
    output logic                        out_valid,
    output logic [afu_pkg::QUO_W-1:0]   quo,
    output afu_pkg::side_t              out_side
);
    localparam int NS = afu_pkg::QUO_W;
    localparam int RW = afu_pkg::DEN_W - 1;

    logic [NS:0]                      vld_reg;
    logic [RW-1:0]                    rem_reg  [0:NS];
    logic [NS-1:0]                    low_reg  [0:NS];
    logic [NS-1:0]                    q_reg    [0:NS];
    logic [afu_pkg::DEN_W-1:0]        den_reg  [0:NS];
    afu_pkg::side_t                   side_reg [0:NS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= RW'(num[afu_pkg::NUM_W-1:NS]);
            low_reg[0]  <= num[NS-1:0];
            q_reg[0]    <= '0;
            den_reg[0]  <= den;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 1; k <= NS; k++) begin : g_stage
        logic [afu_pkg::DEN_W-1:0] trial;
        logic                      ge;
        assign trial = {rem_reg[k-1], low_reg[k-1][NS-1]};
        assign ge    = (trial >= den_reg[k-1]);
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? RW'(trial - den_reg[k-1]) : RW'(trial);
                low_reg[k]  <= {low_reg[k-1][NS-2:0], 1'b0};
                q_reg[k]    <= {q_reg[k-1][NS-2:0], ge};
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[NS];
    assign quo       = q_reg[NS];
    assign out_side  = side_reg[NS];

endmodule

FILE: rtl/core/afu_checker.sv
// Port-level checker for the activation function unit and its bind statement.
// Depends on afu_pkg and activation_function_unit_top.
module afu_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [afu_pkg::DATA_W-1:0] m_result_out,
    input logic                              m_saturated
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_out))
        else $error("Stalled result changed.");

    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> m_result_out == 16'sh7fff || m_result_out == 16'sh8000)
        else $error("Saturation flag without a clamped result.");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("Input stalled while the result register is empty.");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid right after reset.");

endmodule

bind activation_function_unit_top afu_checker u_afu_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_result_out(m_result_out),
    .m_saturated (m_saturated)
);
